// File: design/nmpl_pkg.sv
// ----------------------------------------------------------------------------
// nmpl_pkg
// Shared types and constants for the normal-map point-light blend pipeline.
// ----------------------------------------------------------------------------
package nmpl_pkg;

  localparam int COORD_W  = 9;   // texel coordinate
  localparam int SCREEN_W = 10;  // offset coordinate
  localparam int CHAN_W   = 8;   // color / normal channel
  localparam int LPOS_W   = 12;  // light position
  localparam int RGB_W    = 24;  // packed light color
  localparam int GAIN_W   = 13;  // intensity
  localparam int CFG_W    = 24;  // widest register
  localparam int IDX_W    = 3;   // register index

  localparam int VEC_W    = 13;  // light vector component
  localparam int NRM_W    = 9;   // unbiased normal component
  localparam int PROD_W   = 20;  // vector * normal
  localparam int SQ_W     = 23;  // vector component squared
  localparam int DOT_W    = 21;  // dot product
  localparam int MAG_W    = 25;  // squared length
  localparam int SCL_W    = 33;  // dot * gain
  localparam int REM_W    = 32;  // positive scaled product

  localparam logic signed [NRM_W-1:0] NORMAL_BIAS = 9'sd127;
  localparam logic [CHAN_W-1:0]       ALPHA_MAX   = 8'hFF;

  // Register map
  typedef enum logic [IDX_W-1:0] {
    REG_OFFSET_X    = 3'd0,
    REG_OFFSET_Y    = 3'd1,
    REG_LIGHT_POS_X = 3'd2,
    REG_LIGHT_POS_Y = 3'd3,
    REG_LIGHT_POS_Z = 3'd4,
    REG_LIGHT_RGB   = 3'd5,
    REG_GAIN        = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0]       offset_x;
    logic [COORD_W-1:0]       offset_y;
    logic signed [LPOS_W-1:0] light_pos_x;
    logic signed [LPOS_W-1:0] light_pos_y;
    logic signed [LPOS_W-1:0] light_pos_z;
    logic [RGB_W-1:0]         light_rgb;
    logic signed [GAIN_W-1:0] gain;
  } cfg_t;

  // Fields that ride along the pipeline untouched
  typedef struct packed {
    logic [SCREEN_W-1:0] out_x;
    logic [SCREEN_W-1:0] out_y;
    logic [CHAN_W-1:0]   dest_red;
    logic [CHAN_W-1:0]   dest_green;
    logic [CHAN_W-1:0]   dest_blue;
  } carry_t;

  typedef struct packed {
    carry_t                  carry;
    logic signed [DOT_W-1:0] dot;
    logic [MAG_W-1:0]        mag;
  } geom_t;

  typedef struct packed {
    carry_t            carry;
    logic [CHAN_W-1:0] alpha;
  } shade_t;

endpackage

// File: design/nmpl_if.sv
// ----------------------------------------------------------------------------
// nmpl_texel_if / nmpl_pixel_if
// Valid/ready stream channels for texels in and shaded pixels out.
// ----------------------------------------------------------------------------
interface nmpl_texel_if;
  logic                             valid;
  logic                             ready;
  logic [nmpl_pkg::COORD_W-1:0]     pixel_x;
  logic [nmpl_pkg::COORD_W-1:0]     pixel_y;
  logic [nmpl_pkg::CHAN_W-1:0]      normal_red;
  logic [nmpl_pkg::CHAN_W-1:0]      normal_green;
  logic [nmpl_pkg::CHAN_W-1:0]      normal_blue;
  logic [nmpl_pkg::CHAN_W-1:0]      normal_alpha;
  logic [nmpl_pkg::CHAN_W-1:0]      dest_red;
  logic [nmpl_pkg::CHAN_W-1:0]      dest_green;
  logic [nmpl_pkg::CHAN_W-1:0]      dest_blue;

  modport source (
    output valid, pixel_x, pixel_y, normal_red, normal_green, normal_blue,
           normal_alpha, dest_red, dest_green, dest_blue,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, normal_red, normal_green, normal_blue,
           normal_alpha, dest_red, dest_green, dest_blue,
    output ready
  );
endinterface

interface nmpl_pixel_if;
  logic                             valid;
  logic                             ready;
  logic [nmpl_pkg::SCREEN_W-1:0]    out_x;
  logic [nmpl_pkg::SCREEN_W-1:0]    out_y;
  logic [nmpl_pkg::CHAN_W-1:0]      out_red;
  logic [nmpl_pkg::CHAN_W-1:0]      out_green;
  logic [nmpl_pkg::CHAN_W-1:0]      out_blue;

  modport source (
    output valid, out_x, out_y, out_red, out_green, out_blue,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_red, out_green, out_blue,
    output ready
  );
endinterface

// File: design/normal_map_point_light_blend.sv
// ----------------------------------------------------------------------------
// normal_map_point_light_blend
// Point-light shading of normal-map texels blended over destination pixels.
// ----------------------------------------------------------------------------
//  channel  direction  transaction       payload
//  texel    in         one texel         position, biased normal, alpha, dest rgb
//  pixel    out        one lit pixel     offset position, blended rgb
//  cfg      in         register write    cfg_index 0..6, cfg_data
//
//  One texel per clock while the output is not stalled; the pipeline has
//  eleven stages (vector, multiply, sum, gain multiply, clamp, four division
//  stages, blend multiply, blend sum).
//  Texels with zero alpha are taken and produce no pixel.
//  rst (synchronous) clears every stage valid and loads register defaults.
//  Each stage advances when it is empty or its successor advances, so
//  bubbles close up under a stall and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module normal_map_point_light_blend (
  input  logic                         clk,
  input  logic                         rst,
  nmpl_texel_if.sink                   texel,
  nmpl_pixel_if.source                 pixel,
  input  logic                         cfg_we,
  input  logic [nmpl_pkg::IDX_W-1:0]   cfg_index,
  input  logic [nmpl_pkg::CFG_W-1:0]   cfg_data
);

  nmpl_pkg::cfg_t   cfg;
  logic             geom_valid, geom_ready;
  nmpl_pkg::geom_t  geom_data;
  logic             shade_valid, shade_ready;
  nmpl_pkg::shade_t shade_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_x    <= '0;
      cfg.offset_y    <= '0;
      cfg.light_pos_x <= '0;
      cfg.light_pos_y <= '0;
      cfg.light_pos_z <= '0;
      cfg.light_rgb   <= 24'hFF0000;
      cfg.gain        <= 13'sd64;
    end else if (cfg_we) begin
      case (nmpl_pkg::reg_idx_t'(cfg_index))
        nmpl_pkg::REG_OFFSET_X:    cfg.offset_x    <= cfg_data[8:0];
        nmpl_pkg::REG_OFFSET_Y:    cfg.offset_y    <= cfg_data[8:0];
        nmpl_pkg::REG_LIGHT_POS_X: cfg.light_pos_x <= $signed(cfg_data[11:0]);
        nmpl_pkg::REG_LIGHT_POS_Y: cfg.light_pos_y <= $signed(cfg_data[11:0]);
        nmpl_pkg::REG_LIGHT_POS_Z: cfg.light_pos_z <= $signed(cfg_data[11:0]);
        nmpl_pkg::REG_LIGHT_RGB:   cfg.light_rgb   <= cfg_data[23:0];
        nmpl_pkg::REG_GAIN:        cfg.gain        <= $signed(cfg_data[12:0]);
        default: ;
      endcase
    end
  end

  // Geometry: light vector, dot product, squared length
  nmpl_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .texel     (texel),
    .out_valid (geom_valid),
    .out_ready (geom_ready),
    .out_data  (geom_data)
  );

  // Coverage: scale, divide, clamp
  nmpl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (geom_valid),
    .in_ready  (geom_ready),
    .in_data   (geom_data),
    .out_valid (shade_valid),
    .out_ready (shade_ready),
    .out_data  (shade_data)
  );

  // Color blend and output register
  nmpl_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (shade_valid),
    .in_ready (shade_ready),
    .in_data  (shade_data),
    .pixel    (pixel)
  );

endmodule

// File: design/nmpl_geom.sv
// ----------------------------------------------------------------------------
// nmpl_geom
// Three stages: light vector, products and squares, dot product and length.
// Transparent texels are taken and dropped at the first stage.
// ----------------------------------------------------------------------------
module nmpl_geom (
  input  logic                 clk,
  input  logic                 rst,
  input  nmpl_pkg::cfg_t       cfg,
  nmpl_texel_if.sink           texel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nmpl_pkg::geom_t      out_data
);

  // Stage valids and advance enables
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3 = !v3 || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign texel.ready = en1;

  // ---- stage 1: light vector and unbiased normal ----
  nmpl_pkg::carry_t                      c1, c2, c3;
  logic signed [nmpl_pkg::VEC_W-1:0]     lx, ly, lz;
  logic signed [nmpl_pkg::NRM_W-1:0]     nr, ng, nb;

  logic signed [nmpl_pkg::VEC_W-1:0]     lpx_ext, lpy_ext, lpz_ext;
  logic signed [nmpl_pkg::VEC_W-1:0]     px_ext, py_ext;
  nmpl_pkg::carry_t                      c1_next;

  assign lpx_ext = {cfg.light_pos_x[nmpl_pkg::LPOS_W-1], cfg.light_pos_x};
  assign lpy_ext = {cfg.light_pos_y[nmpl_pkg::LPOS_W-1], cfg.light_pos_y};
  assign lpz_ext = {cfg.light_pos_z[nmpl_pkg::LPOS_W-1], cfg.light_pos_z};
  assign px_ext  = $signed({4'b0000, texel.pixel_x});
  assign py_ext  = $signed({4'b0000, texel.pixel_y});

  always_comb begin
    c1_next.out_x      = {1'b0, texel.pixel_x} + {1'b0, cfg.offset_x};
    c1_next.out_y      = {1'b0, texel.pixel_y} + {1'b0, cfg.offset_y};
    c1_next.dest_red   = texel.dest_red;
    c1_next.dest_green = texel.dest_green;
    c1_next.dest_blue  = texel.dest_blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= texel.valid && (texel.normal_alpha != '0);
    end
    if (en1) begin
      c1 <= c1_next;
      lx <= lpx_ext - px_ext;
      ly <= py_ext - lpy_ext;
      lz <= -lpz_ext;
      nr <= $signed({1'b0, texel.normal_red})   - nmpl_pkg::NORMAL_BIAS;
      ng <= $signed({1'b0, texel.normal_green}) - nmpl_pkg::NORMAL_BIAS;
      nb <= $signed({1'b0, texel.normal_blue})  - nmpl_pkg::NORMAL_BIAS;
    end
  end

  // ---- stage 2: component products and squares ----
  logic signed [21:0] mxn, myn, mzn;
  logic signed [25:0] mxx, myy, mzz;
  logic signed [nmpl_pkg::PROD_W-1:0] pxn, pyn, pzn;
  logic [nmpl_pkg::SQ_W-1:0]          sxx, syy, szz;

  assign mxn = lx * nr;
  assign myn = ly * ng;
  assign mzn = lz * nb;
  assign mxx = lx * lx;
  assign myy = ly * ly;
  assign mzz = lz * lz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      c2  <= c1;
      pxn <= mxn[nmpl_pkg::PROD_W-1:0];
      pyn <= myn[nmpl_pkg::PROD_W-1:0];
      pzn <= mzn[nmpl_pkg::PROD_W-1:0];
      sxx <= mxx[nmpl_pkg::SQ_W-1:0];
      syy <= myy[nmpl_pkg::SQ_W-1:0];
      szz <= mzz[nmpl_pkg::SQ_W-1:0];
    end
  end

  // ---- stage 3: dot product and squared length ----
  logic signed [nmpl_pkg::DOT_W-1:0] dot;
  logic [nmpl_pkg::MAG_W-1:0]        mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      c3  <= c2;
      dot <= $signed({pxn[nmpl_pkg::PROD_W-1], pxn})
           + $signed({pyn[nmpl_pkg::PROD_W-1], pyn})
           + $signed({pzn[nmpl_pkg::PROD_W-1], pzn});
      mag <= {2'b00, sxx} + {2'b00, syy} + {2'b00, szz};
    end
  end

  assign out_valid      = v3;
  assign out_data.carry = c3;
  assign out_data.dot   = dot;
  assign out_data.mag   = mag;

endmodule

// File: design/nmpl_div.sv
// ----------------------------------------------------------------------------
// nmpl_div
// Scales the dot product by the gain and divides by the squared length,
// giving a coverage clamped to 0..255. One multiply stage, one saturation
// stage, then four restoring-division stages of two quotient bits each.
// ----------------------------------------------------------------------------
module nmpl_div (
  input  logic                 clk,
  input  logic                 rst,
  input  nmpl_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nmpl_pkg::geom_t      in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nmpl_pkg::shade_t     out_data
);

  localparam int DIV_STAGES = 4;

  typedef struct packed {
    nmpl_pkg::carry_t                 carry;
    logic [nmpl_pkg::REM_W-1:0]       rem;
    logic [nmpl_pkg::CHAN_W-1:0]      quot;
    logic [nmpl_pkg::MAG_W-1:0]       mag;
    logic                             pos;
    logic                             sat;
  } div_stage_t;

  logic v1, v2;
  logic en1, en2;
  logic       dv_valid [DIV_STAGES];
  logic       dv_en    [DIV_STAGES];
  div_stage_t dv_data  [DIV_STAGES];

  assign en2      = !v2 || dv_en[0];
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // ---- stage 1: dot * gain ----
  nmpl_pkg::carry_t                   c1;
  logic signed [nmpl_pkg::SCL_W-1:0]  q;
  logic [nmpl_pkg::MAG_W-1:0]         mag1;
  logic signed [33:0]                 q_full;

  assign q_full = $signed(in_data.dot) * $signed(cfg.gain);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      c1   <= in_data.carry;
      q    <= q_full[nmpl_pkg::SCL_W-1:0];
      mag1 <= in_data.mag;
    end
  end

  // ---- stage 2: sign and saturation check ----
  // A zero length means a zero light vector, hence a zero product.
  div_stage_t d2, d2_next;

  always_comb begin
    d2_next.carry = c1;
    d2_next.rem   = q[nmpl_pkg::REM_W-1:0];
    d2_next.quot  = '0;
    d2_next.mag   = mag1;
    d2_next.pos   = !q[nmpl_pkg::SCL_W-1] && (q != '0);
    d2_next.sat   = {1'b0, q[nmpl_pkg::REM_W-1:0]} >= {mag1, 8'h00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      d2 <= d2_next;
    end
  end

  // ---- stages 3..6: two quotient bits per stage ----
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    div_stage_t src;
    logic       src_valid;
    div_stage_t nxt;

    if (j == 0) begin : g_first
      assign src       = d2;
      assign src_valid = v2;
    end else begin : g_rest
      assign src       = dv_data[j-1];
      assign src_valid = dv_valid[j-1];
    end

    if (j == DIV_STAGES - 1) begin : g_last_en
      assign dv_en[j] = !dv_valid[j] || out_ready;
    end else begin : g_mid_en
      assign dv_en[j] = !dv_valid[j] || dv_en[j+1];
    end

    // Restoring step: subtract mag shifted to the current bit when it fits
    always_comb begin
      logic [nmpl_pkg::REM_W-1:0] trial;
      nxt = src;
      for (int k = 0; k < 2; k++) begin
        trial = {7'b0, src.mag} << (nmpl_pkg::CHAN_W - 1 - 2 * j - k);
        if (nxt.rem >= trial) begin
          nxt.rem = nxt.rem - trial;
          nxt.quot[nmpl_pkg::CHAN_W - 1 - 2 * j - k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j] <= 1'b0;
      end else if (dv_en[j]) begin
        dv_valid[j] <= src_valid;
      end
      if (dv_en[j]) begin
        dv_data[j] <= nxt;
      end
    end
  end

  // Clamp: non-positive products read 0, saturated quotients read 255
  div_stage_t last;
  assign last           = dv_data[DIV_STAGES-1];
  assign out_valid      = dv_valid[DIV_STAGES-1];
  assign out_data.carry = last.carry;
  assign out_data.alpha = !last.pos ? '0 :
                          (last.sat ? nmpl_pkg::ALPHA_MAX : last.quot);

endmodule

// File: design/nmpl_blend.sv
// ----------------------------------------------------------------------------
// nmpl_blend
// Blends the light color over the destination with the computed coverage:
// (dst*(255-a) + light*a) >> 8 per channel. Products in one stage, sums in
// the output register.
// ----------------------------------------------------------------------------
module nmpl_blend (
  input  logic                 clk,
  input  logic                 rst,
  input  nmpl_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nmpl_pkg::shade_t     in_data,
  nmpl_pixel_if.source         pixel
);

  localparam int NCH = 3;

  logic v1, v2;
  logic en1, en2;

  assign en2      = !v2 || pixel.ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // ---- stage 1: weighted products ----
  logic [nmpl_pkg::CHAN_W-1:0]   dst [NCH];
  logic [nmpl_pkg::CHAN_W-1:0]   lit [NCH];
  logic [nmpl_pkg::CHAN_W-1:0]   inv_alpha;
  logic [2*nmpl_pkg::CHAN_W-1:0] pd [NCH];
  logic [2*nmpl_pkg::CHAN_W-1:0] pl [NCH];
  logic [nmpl_pkg::SCREEN_W-1:0] x1, y1;

  assign dst[0]    = in_data.carry.dest_red;
  assign dst[1]    = in_data.carry.dest_green;
  assign dst[2]    = in_data.carry.dest_blue;
  assign lit[0]    = cfg.light_rgb[23:16];
  assign lit[1]    = cfg.light_rgb[15:8];
  assign lit[2]    = cfg.light_rgb[7:0];
  assign inv_alpha = nmpl_pkg::ALPHA_MAX - in_data.alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      x1 <= in_data.carry.out_x;
      y1 <= in_data.carry.out_y;
      for (int c = 0; c < NCH; c++) begin
        pd[c] <= {8'h00, dst[c]} * {8'h00, inv_alpha};
        pl[c] <= {8'h00, lit[c]} * {8'h00, in_data.alpha};
      end
    end
  end

  // ---- stage 2: sums, output register ----
  logic [2*nmpl_pkg::CHAN_W-1:0] sum [NCH];
  logic [nmpl_pkg::CHAN_W-1:0]   res [NCH];
  logic [nmpl_pkg::SCREEN_W-1:0] x2, y2;

  // Both weights add to 255, so the sum stays within 16 bits
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum[c] = pd[c] + pl[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      x2 <= x1;
      y2 <= y1;
      for (int c = 0; c < NCH; c++) begin
        res[c] <= sum[c][2*nmpl_pkg::CHAN_W-1:nmpl_pkg::CHAN_W];
      end
    end
  end

  assign pixel.valid     = v2;
  assign pixel.out_x     = x2;
  assign pixel.out_y     = y2;
  assign pixel.out_red   = res[0];
  assign pixel.out_green = res[1];
  assign pixel.out_blue  = res[2];

endmodule

// File: design/nmpl_check.sv
// ----------------------------------------------------------------------------
// nmpl_check
// Port-level checks for the point-light blend pipeline, bound to the top.
// ----------------------------------------------------------------------------
module nmpl_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [nmpl_pkg::SCREEN_W-1:0] out_x,
  input logic [nmpl_pkg::SCREEN_W-1:0] out_y,
  input logic [nmpl_pkg::CHAN_W-1:0]   out_red,
  input logic [nmpl_pkg::CHAN_W-1:0]   out_green,
  input logic [nmpl_pkg::CHAN_W-1:0]   out_blue
);

  // A stalled pixel stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel dropped while stalled");

  // A stalled pixel keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(out_x) && $stable(out_y) && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue))
    else $error("pixel payload changed while stalled");

  // A free output lets every stage advance, so a texel is always taken
  a_ready_flow: assert property (@(posedge clk)
    out_ready |-> in_ready)
    else $error("texel refused while output is free");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("pixel offered right after reset");

endmodule

bind normal_map_point_light_blend nmpl_check u_nmpl_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (texel.ready),
  .out_valid (pixel.valid),
  .out_ready (pixel.ready),
  .out_x     (pixel.out_x),
  .out_y     (pixel.out_y),
  .out_red   (pixel.out_red),
  .out_green (pixel.out_green),
  .out_blue  (pixel.out_blue)
);

// File: tb/tb_normal_map_point_light_blend.sv
// ----------------------------------------------------------------------------
// tb_normal_map_point_light_blend
// Self-checking bench for the point-light normal-map blend pipeline. A queue of
// texels feeds a valid/ready driver while a monitor predicts every lit pixel
// from its own copy of the light registers and compares the output stream
// field by field. Directed texels cover the extremes and the special cases;
// random phases follow, each under fresh light settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_normal_map_point_light_blend;
  timeunit 1ns;
  timeprecision 1ps;

  import nmpl_pkg::*;

  localparam int PIPE_LATENCY   = 11;
  localparam int DRAIN_PAD      = PIPE_LATENCY + 5;
  localparam int IDLE_LIMIT     = 2000;
  localparam int PHASE_TEXELS   = 250;
  localparam int RANDOM_PHASES  = 6;
  localparam int LONG_HOLD      = 150;
  localparam int HOLD_SPACING   = 600;
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;  // outside the register map
  localparam longint NORMAL_ZERO = 127;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  normal_red;
    logic [CHAN_W-1:0]  normal_green;
    logic [CHAN_W-1:0]  normal_blue;
    logic [CHAN_W-1:0]  normal_alpha;
    logic [CHAN_W-1:0]  dest_red;
    logic [CHAN_W-1:0]  dest_green;
    logic [CHAN_W-1:0]  dest_blue;
  } texel_t;

  typedef struct packed {
    logic [SCREEN_W-1:0] out_x;
    logic [SCREEN_W-1:0] out_y;
    logic [CHAN_W-1:0]   out_red;
    logic [CHAN_W-1:0]   out_green;
    logic [CHAN_W-1:0]   out_blue;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  nmpl_texel_if texel_bus ();
  nmpl_pixel_if pixel_bus ();

  normal_map_point_light_blend uut (
    .clk       (clk),
    .rst       (rst),
    .texel     (texel_bus),
    .pixel     (pixel_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Light registers as the block should hold them
  cfg_t light_cfg;

  texel_t texel_q[$];   // texels waiting to be offered
  pixel_t lit_q[$];     // lit pixels still owed by the block

  int sender_mode;      // 0: no gaps, 1: light, 2: heavy
  int receiver_mode;
  int send_gap;
  int stall_left;
  int hold_left;
  int next_hold_at;
  bit texel_taken;
  int texels_in;
  int pixels_out;
  int texels_skipped;
  int cov_dark, cov_full, cov_partial, long_holds;
  int idle_cycles;
  int errors;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [CHAN_W-1:0] blend_channel(input logic [CHAN_W-1:0] dst,
                                                      input logic [CHAN_W-1:0] lit,
                                                      input int unsigned a);
    int unsigned mix;
    mix = dst * (255 - a) + lit * a;
    return CHAN_W'(mix >> 8);
  endfunction

  function automatic pixel_t shade_texel(input texel_t t, output int coverage);
    longint lpos, lx, ly, lz, nr, ng, nb, dot, mag, q;
    pixel_t p;
    lpos = light_cfg.light_pos_x;
    lx   = lpos - longint'(t.pixel_x);
    lpos = light_cfg.light_pos_y;
    ly   = longint'(t.pixel_y) - lpos;
    lpos = light_cfg.light_pos_z;
    lz   = -lpos;
    nr   = longint'(t.normal_red) - NORMAL_ZERO;
    ng   = longint'(t.normal_green) - NORMAL_ZERO;
    nb   = longint'(t.normal_blue) - NORMAL_ZERO;
    dot  = lx * nr + ly * ng + lz * nb;
    mag  = lx * lx + ly * ly + lz * lz;
    lpos = light_cfg.gain;
    q    = dot * lpos;
    // light sitting on the texel: no division
    if (mag != 0) q = q / mag;
    if (q > 255) q = 255;
    if (q < 0) q = 0;
    coverage    = int'(q);
    p.out_x     = t.pixel_x + light_cfg.offset_x;
    p.out_y     = t.pixel_y + light_cfg.offset_y;
    p.out_red   = blend_channel(t.dest_red, light_cfg.light_rgb[23:16], coverage);
    p.out_green = blend_channel(t.dest_green, light_cfg.light_rgb[15:8], coverage);
    p.out_blue  = blend_channel(t.dest_blue, light_cfg.light_rgb[7:0], coverage);
    return p;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d (pixel %0d)",
             $realtime, field, got, want, pixels_out);
    errors++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int draw_gap(input int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (mode == 1 && r < 70) return 0;
    if (mode == 2 && r < 35) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t want;
    texel_t t;
    int coverage;
    if (!rst) begin
      texel_taken = texel_bus.valid && texel_bus.ready;
      if (texel_taken) begin
        texels_in++;
        t.pixel_x      = texel_bus.pixel_x;
        t.pixel_y      = texel_bus.pixel_y;
        t.normal_red   = texel_bus.normal_red;
        t.normal_green = texel_bus.normal_green;
        t.normal_blue  = texel_bus.normal_blue;
        t.normal_alpha = texel_bus.normal_alpha;
        t.dest_red     = texel_bus.dest_red;
        t.dest_green   = texel_bus.dest_green;
        t.dest_blue    = texel_bus.dest_blue;
        // transparent texel yields nothing
        if (t.normal_alpha == '0) begin
          texels_skipped++;
        end else begin
          lit_q.push_back(shade_texel(t, coverage));
          if (coverage == 0) cov_dark++;
          else if (coverage == 255) cov_full++;
          else cov_partial++;
        end
      end
      if (pixel_bus.valid && pixel_bus.ready) begin
        pixels_out++;
        if (lit_q.size() == 0) begin
          $display("[%0t] pixel transaction with nothing expected (%0d,%0d)",
                   $realtime, pixel_bus.out_x, pixel_bus.out_y);
          errors++;
        end else begin
          want = lit_q.pop_front();
          if (pixel_bus.out_x !== want.out_x)
            report_mismatch("out_x", pixel_bus.out_x, want.out_x);
          if (pixel_bus.out_y !== want.out_y)
            report_mismatch("out_y", pixel_bus.out_y, want.out_y);
          if (pixel_bus.out_red !== want.out_red)
            report_mismatch("out_red", pixel_bus.out_red, want.out_red);
          if (pixel_bus.out_green !== want.out_green)
            report_mismatch("out_green", pixel_bus.out_green, want.out_green);
          if (pixel_bus.out_blue !== want.out_blue)
            report_mismatch("out_blue", pixel_bus.out_blue, want.out_blue);
        end
      end
      // watchdog on cycles without any transaction
      if (texel_taken || (pixel_bus.valid && pixel_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("[%0t] no transaction for %0d cycles, %0d pixels outstanding",
                   $realtime, IDLE_LIMIT, lit_q.size());
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Texel driver: falling edge, fed from texel_q
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    texel_t t;
    if (!rst && (!texel_bus.valid || texel_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        texel_bus.valid <= 1'b0;
      end else if (texel_q.size() != 0) begin
        t = texel_q.pop_front();
        texel_bus.pixel_x      <= t.pixel_x;
        texel_bus.pixel_y      <= t.pixel_y;
        texel_bus.normal_red   <= t.normal_red;
        texel_bus.normal_green <= t.normal_green;
        texel_bus.normal_blue  <= t.normal_blue;
        texel_bus.normal_alpha <= t.normal_alpha;
        texel_bus.dest_red     <= t.dest_red;
        texel_bus.dest_green   <= t.dest_green;
        texel_bus.dest_blue    <= t.dest_blue;
        texel_bus.valid        <= 1'b1;
        send_gap = draw_gap(sender_mode);
      end else begin
        texel_bus.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pixel receiver: random stalls plus a periodic long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left == 0 && texels_in >= next_hold_at) begin
        hold_left = LONG_HOLD;
        next_hold_at += HOLD_SPACING;
        long_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pixel_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pixel_bus.ready <= 1'b0;
      end else begin
        pixel_bus.ready <= 1'b1;
        stall_left = draw_gap(receiver_mode);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic texel_t make_texel(input int px, input int py, input int nr,
                                        input int ng, input int nb, input int na,
                                        input int dr, input int dg, input int db);
    texel_t t;
    t.pixel_x      = COORD_W'(px);
    t.pixel_y      = COORD_W'(py);
    t.normal_red   = CHAN_W'(nr);
    t.normal_green = CHAN_W'(ng);
    t.normal_blue  = CHAN_W'(nb);
    t.normal_alpha = CHAN_W'(na);
    t.dest_red     = CHAN_W'(dr);
    t.dest_green   = CHAN_W'(dg);
    t.dest_blue    = CHAN_W'(db);
    return t;
  endfunction

  // Register write at the falling edge; the shadow copy follows right away
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_OFFSET_X:    light_cfg.offset_x    = val[COORD_W-1:0];
      REG_OFFSET_Y:    light_cfg.offset_y    = val[COORD_W-1:0];
      REG_LIGHT_POS_X: light_cfg.light_pos_x = val[LPOS_W-1:0];
      REG_LIGHT_POS_Y: light_cfg.light_pos_y = val[LPOS_W-1:0];
      REG_LIGHT_POS_Z: light_cfg.light_pos_z = val[LPOS_W-1:0];
      REG_LIGHT_RGB:   light_cfg.light_rgb   = val[RGB_W-1:0];
      REG_GAIN:        light_cfg.gain        = val[GAIN_W-1:0];
      default: ;  // unmapped index is dropped
    endcase
  endtask

  task automatic set_lighting(input int ox, input int oy, input int lx, input int ly,
                              input int lz, input int rgb, input int gain);
    write_reg(REG_OFFSET_X, CFG_W'(ox));
    write_reg(REG_OFFSET_Y, CFG_W'(oy));
    write_reg(REG_LIGHT_POS_X, CFG_W'(lx));
    write_reg(REG_LIGHT_POS_Y, CFG_W'(ly));
    write_reg(REG_LIGHT_POS_Z, CFG_W'(lz));
    write_reg(REG_LIGHT_RGB, CFG_W'(rgb));
    write_reg(REG_GAIN, CFG_W'(gain));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender pause: everything offered, taken and answered, then the pipe settles
  task automatic wait_drained();
    while (texel_q.size() != 0 || texel_bus.valid || lit_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int lx, ly, lz, g, px, py;
    texel_bus.valid        = 1'b0;
    texel_bus.pixel_x      = '0;
    texel_bus.pixel_y      = '0;
    texel_bus.normal_red   = '0;
    texel_bus.normal_green = '0;
    texel_bus.normal_blue  = '0;
    texel_bus.normal_alpha = '0;
    texel_bus.dest_red     = '0;
    texel_bus.dest_green   = '0;
    texel_bus.dest_blue    = '0;
    pixel_bus.ready        = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst       = 1'b1;
    sender_mode   = 0;
    receiver_mode = 0;
    send_gap = 0; stall_left = 0; hold_left = 0;
    next_hold_at = 400;
    texel_taken = 1'b0;
    texels_in = 0; pixels_out = 0; texels_skipped = 0;
    cov_dark = 0; cov_full = 0; cov_partial = 0; long_holds = 0;
    idle_cycles = 0; errors = 0;

    // reset values of the light registers
    light_cfg = '0;
    light_cfg.light_rgb = 24'hFF0000;
    light_cfg.gain      = 13'sd64;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings, light at the origin
    texel_q.push_back(make_texel(5, 5, 200, 100, 60, 0, 1, 2, 3));         // transparent
    texel_q.push_back(make_texel(0, 0, 255, 255, 255, 255, 255, 255, 255)); // light on texel
    texel_q.push_back(make_texel(1, 0, 0, 127, 127, 1, 0, 0, 0));           // saturates
    texel_q.push_back(make_texel(1, 0, 255, 127, 127, 128, 90, 90, 90));    // negative dot
    texel_q.push_back(make_texel(511, 511, 255, 0, 255, 255, 255, 0, 128));
    texel_q.push_back(make_texel(40, 3, 0, 255, 0, 17, 200, 100, 50));
    wait_drained();

    // Upper extremes: offsets carry the output past 511, white light, max gain
    set_lighting(511, 511, 2047, 2047, 2047, 24'hFFFFFF, 4095);
    texel_q.push_back(make_texel(0, 0, 0, 0, 0, 255, 0, 0, 0));
    texel_q.push_back(make_texel(511, 511, 255, 255, 255, 255, 255, 255, 255));
    texel_q.push_back(make_texel(511, 0, 255, 0, 0, 64, 10, 20, 30));
    texel_q.push_back(make_texel(0, 511, 0, 255, 255, 0, 10, 20, 30));      // transparent
    wait_drained();

    // Lower extremes: black light, most negative gain and positions
    set_lighting(0, 0, -2048, -2048, -2048, 24'h000000, -4096);
    texel_q.push_back(make_texel(511, 0, 0, 0, 0, 255, 255, 255, 255));
    texel_q.push_back(make_texel(0, 511, 255, 255, 255, 255, 128, 64, 32));
    texel_q.push_back(make_texel(256, 256, 127, 127, 127, 2, 7, 8, 9));
    wait_drained();

    // Light just above a texel, then in its plane; unmapped index is ignored
    set_lighting(100, 37, 200, 100, -50, 24'h40C020, 300);
    write_reg(REG_NONE, 24'hA5A5A5);
    @(negedge clk);
    cfg_we <= 1'b0;
    texel_q.push_back(make_texel(200, 100, 127, 127, 255, 255, 30, 60, 90));
    texel_q.push_back(make_texel(200, 100, 127, 127, 0, 255, 30, 60, 90));
    texel_q.push_back(make_texel(190, 110, 150, 90, 200, 200, 250, 5, 128));
    texel_q.push_back(make_texel(230, 70, 100, 140, 180, 99, 0, 255, 0));
    wait_drained();
    write_reg(REG_LIGHT_POS_Z, 0);
    @(negedge clk);
    cfg_we <= 1'b0;
    texel_q.push_back(make_texel(200, 100, 0, 255, 200, 255, 100, 150, 200));
    texel_q.push_back(make_texel(201, 100, 0, 127, 127, 255, 100, 150, 200));
    texel_q.push_back(make_texel(210, 95, 200, 60, 127, 255, 100, 150, 200));
    wait_drained();

    // Random phases under fresh light settings and idling patterns
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      sender_mode   = (ph == 0) ? 0 : $urandom_range(0, 2);
      receiver_mode = (ph == 0) ? 0 : $urandom_range(0, 2);
      lx = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 639)) - 64
                                       : int'($urandom_range(0, 4095)) - 2048;
      ly = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 639)) - 64
                                       : int'($urandom_range(0, 4095)) - 2048;
      case ($urandom_range(0, 3))
        0:       lz = 0;
        1:       lz = int'($urandom_range(0, 4095)) - 2048;
        default: lz = int'($urandom_range(0, 512)) - 256;
      endcase
      case ($urandom_range(0, 3))
        0:       g = int'($urandom_range(0, 8191)) - 4096;
        1:       g = -int'($urandom_range(1, 4096));
        default: g = $urandom_range(0, 1023);
      endcase
      set_lighting($urandom(), $urandom(), lx, ly, lz, $urandom(), g);
      for (int n = 0; n < PHASE_TEXELS; n++) begin
        px = $urandom_range(0, 511);
        py = $urandom_range(0, 511);
        // now and then land right under the light
        if ($urandom_range(0, 9) == 0 && lx >= 0 && lx <= 511 && ly >= 0 && ly <= 511) begin
          px = lx + int'($urandom_range(0, 2)) - 1;
          py = ly + int'($urandom_range(0, 2)) - 1;
        end
        texel_q.push_back(make_texel(px, py, $urandom(), $urandom(), $urandom(),
                                     ($urandom_range(0, 6) == 0) ? 0 : $urandom(),
                                     $urandom(), $urandom(), $urandom()));
      end
      wait_drained();
    end

    $display("Run covered %0d texels (%0d transparent) and %0d lit pixels;",
             texels_in, texels_skipped, pixels_out);
    $display("coverage dark/partial/full %0d/%0d/%0d, %0d long output hold-offs.",
             cov_dark, cov_partial, cov_full, long_holds);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: normal_map_point_light_blend.f
design/nmpl_pkg.sv
design/nmpl_if.sv
design/nmpl_geom.sv
design/nmpl_div.sv
design/nmpl_blend.sv
design/normal_map_point_light_blend.sv
design/nmpl_check.sv
tb/tb_normal_map_point_light_blend.sv
